// ----- rtl/aes_ctr_pkg.sv -----
package aes_ctr_pkg;

  localparam logic [1:0] REQ_DATA     = 2'd0;
  localparam logic [1:0] REQ_LOAD_HI  = 2'd1;
  localparam logic [1:0] REQ_LOAD_LO  = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- rtl/aes_ctr_keyexp.sv -----
module aes_ctr_keyexp
  import aes_ctr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [127:0] key,
  input  logic         rebuild,
  input  logic [3:0]   rd_round,
  output logic [127:0] rd_key,
  output logic         busy
);

  logic [127:0] keys [11];
  logic [127:0] cur;
  logic [3:0]   idx;
  logic         run;
  logic [31:0]  t;
  logic [31:0]  w0, w1, w2, w3;

  assign t  = sub_word({cur[23:0], cur[31:24]}) ^ {RCON[idx], 24'h0};
  assign w0 = cur[127:96] ^ t;
  assign w1 = cur[95:64] ^ w0;
  assign w2 = cur[63:32] ^ w1;
  assign w3 = cur[31:0] ^ w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b1;
      idx <= 4'd1;
      cur <= '0;
    end else if (rebuild) begin
      run <= 1'b1;
      idx <= 4'd1;
      cur <= key;
    end else if (run) begin
      cur <= {w0, w1, w2, w3};
      if (idx == 4'd10) run <= 1'b0;
      else idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) keys[0] <= '0;
    else if (rebuild) keys[0] <= key;
    else if (run) keys[idx] <= {w0, w1, w2, w3};
  end

  assign rd_key = keys[rd_round];
  assign busy   = run | rebuild;

endmodule

// ----- rtl/aes_ctr_round.sv -----
module aes_ctr_round
  import aes_ctr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  core_ctl_t    ctl_in,
  input  block_t       din,
  input  logic [127:0] rkey,
  output logic [3:0]   round,
  output core_ctl_t    ctl_out,
  output block_t       dout
);

  block_t     st;
  block_t     sh;
  block_t     mx;
  logic       run;
  logic       done;
  logic [7:0] a, b, c2, c3, al;

  always_comb begin
    sh = '0;
    mx = '0;
    a = '0; b = '0; c2 = '0; c3 = '0; al = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sh[127 - 8*(c*4 + r) -: 8] = SBOX[st[127 - 8*((((c + r) & 3) * 4) + r) -: 8]];
    for (int c = 0; c < 4; c++) begin
      a  = sh[127 - 32*c -: 8];
      b  = sh[119 - 32*c -: 8];
      c2 = sh[111 - 32*c -: 8];
      c3 = sh[103 - 32*c -: 8];
      al = a ^ b ^ c2 ^ c3;
      mx[127 - 32*c -: 8] = a ^ al ^ xtime(a ^ b);
      mx[119 - 32*c -: 8] = b ^ al ^ xtime(b ^ c2);
      mx[111 - 32*c -: 8] = c2 ^ al ^ xtime(c2 ^ c3);
      mx[103 - 32*c -: 8] = c3 ^ al ^ xtime(c3 ^ a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start && !run) begin
        run   <= 1'b1;
        round <= 4'd1;
      end else if (run) begin
        if (round == 4'd10) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else round <= round + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start && !run) st <= din ^ rkey;
    else if (run) st <= ((round == 4'd10) ? sh : mx) ^ rkey;
  end

  assign dout    = st;
  assign ctl_out = '{start: 1'b0, busy: run, done: done};

endmodule

// ----- rtl/aes128_ctr_stream_cipher.sv -----
// AES-128 counter-mode byte cipher, one byte at a time. A data byte with a
// nonzero keystream offset and no first_of_message flag is XORed with the
// stored keystream block; otherwise a new keystream block is computed first
// (one shared AES round unit, 10 rounds plus setup). A key write rebuilds the
// round-key table, during which no item is accepted. Counter reads give two
// transactions, high half first; counter loads give none.
module aes128_ctr_stream_cipher
  import aes_ctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // data_byte[7:0], load_word[71:8], zero pad
  input  logic [2:0]  s_tuser,   // req_type[1:0], first_of_message[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // result_value[63:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ENC  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_XOR  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_OUT2 = 3'd5;

  logic [2:0]   state;
  logic [63:0]  key_high, key_low;
  logic [127:0] counter;
  logic [127:0] ks;
  logic [3:0]   offset;
  logic [7:0]   data;
  logic         rebuild;
  logic         kbusy;
  logic [3:0]   round;
  logic [127:0] rkey;
  core_ctl_t    ctl_in, ctl_out;
  block_t       enc;
  logic         acc;

  assign cfg_ready = (state == ST_IDLE);
  assign rebuild   = cfg_valid && cfg_ready;
  assign s_tready  = (state == ST_IDLE) && !kbusy;
  assign acc       = s_tvalid && s_tready;
  assign ctl_in    = '{start: (state == ST_ENC), busy: 1'b0, done: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (rebuild) begin
      if (cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      else key_low <= cfg_data;
    end
  end

  aes_ctr_keyexp u_keyexp (
    .clk(clk), .rst(rst),
    .key(rebuild ? ((cfg_index == REG_KEY_HIGH) ? {cfg_data, key_low}
                                                : {key_high, cfg_data})
                 : {key_high, key_low}),
    .rebuild(rebuild), .rd_round(state == ST_ENC ? 4'd0 : round),
    .rd_key(rkey), .busy(kbusy)
  );

  aes_ctr_round u_round (
    .clk(clk), .rst(rst), .ctl_in(ctl_in), .din(counter), .rkey(rkey),
    .round(round), .ctl_out(ctl_out), .dout(enc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      counter  <= '0;
      offset   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (acc) begin
          unique case (s_tuser[1:0])
            REQ_DATA: begin
              data <= s_tdata[7:0];
              if (s_tuser[2] || offset == 4'd0) begin
                offset <= 4'd0;
                state  <= ST_ENC;
              end else state <= ST_XOR;
            end
            REQ_LOAD_HI: counter[127:64] <= s_tdata[71:8];
            REQ_LOAD_LO: counter[63:0] <= s_tdata[71:8];
            REQ_READ: begin
              m_tdata  <= counter[127:64];
              m_tlast  <= 1'b0;
              m_tvalid <= 1'b1;
              state    <= ST_OUT2;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_ENC: state <= ST_WAIT;
        ST_WAIT: if (ctl_out.done) begin
          ks      <= enc;
          counter <= counter + 128'd1;
          state   <= ST_XOR;
        end
        ST_XOR: begin
          m_tdata  <= {56'h0, data ^ ks[127 - {offset, 3'b000} -: 8]};
          m_tlast  <= 1'b1;
          m_tvalid <= 1'b1;
          offset   <= offset + 4'd1;
          state    <= ST_OUT;
        end
        ST_OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state    <= ST_IDLE;
        end
        ST_OUT2: if (m_tready) begin
          m_tdata <= counter[63:0];
          m_tlast <= 1'b1;
          state   <= ST_OUT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT || state == ST_OUT2) |-> m_tvalid) else $error("lost result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_out.busy |-> !s_tready) else $error("accept during encrypt");
  a_enc_done: assert property (@(posedge clk) disable iff (rst)
    ctl_out.done |-> state == ST_WAIT) else $error("stray done");

endmodule
